@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL. Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ rtl/ptpc_pkg.sv @@
`default_nettype none

package ptpc_pkg;

    // item kinds
    typedef enum logic [1:0] {
        KIND_STD_CMD = 2'd0,
        KIND_NSI_CMD = 2'd1,
        KIND_STATUS  = 2'd2,
        KIND_TICK    = 2'd3
    } kind_t;

    // configuration register indexes
    localparam logic [1:0] CFG_UNIT_ADDR = 2'd0;
    localparam logic [1:0] CFG_STD_IF    = 2'd1;
    localparam logic [1:0] CFG_TAPE      = 2'd2;
    localparam logic [1:0] CFG_PARITY    = 2'd3;

    // punch codes
    localparam logic [1:0] PAR_7P = 2'd1;
    localparam logic [1:0] PAR_7X = 2'd2;

    // mode flag masks
    localparam logic [5:0] M_ALPHA = 6'o01;
    localparam logic [5:0] M_BIN   = 6'o02;
    localparam logic [5:0] M_BLANK = 6'o04;
    localparam logic [5:0] M_DISC  = 6'o10;
    localparam logic [5:0] M_BUSY  = 6'o20;
    localparam logic [5:0] M_DELTA = 6'o40;
    localparam logic [5:0] M_HOLD  = M_BUSY | M_DISC | M_BIN | M_BLANK;

    // status masks
    localparam logic [2:0] S_TERM = 3'o1;
    localparam logic [2:0] S_OPAT = 3'o2;
    localparam logic [2:0] S_ERR  = 3'o4;

    // standard interface command groups and codes
    localparam logic [2:0] GRP_START = 3'o1;
    localparam logic [2:0] GRP_STAT  = 3'o2;
    localparam logic [2:0] GRP_CTRL  = 3'o3;
    localparam logic [5:0] CMD_SENSE = 6'o20;
    localparam logic [5:0] CMD_CLEAR = 6'o24;
    localparam logic [5:0] CMD_DISC  = 6'o36;
    localparam logic [5:0] RESP_BUSY = 6'd3;
    localparam logic [5:0] RESP_ACK  = 6'd5;

    // shift characters
    localparam logic [5:0] CH_ALPHA   = 6'o74;
    localparam logic [5:0] CH_BETA    = 6'o75;
    localparam logic [5:0] CH_DELTA   = 6'o76;
    localparam logic [5:0] CH_DELTA_A = 6'o77;

    // 7X swap codes
    localparam logic [7:0] X_DOLLAR = 8'o044;
    localparam logic [7:0] X_POUND  = 8'o243;
    localparam logic [7:0] X_BAR    = 8'o174;

    typedef struct packed {
        logic [5:0] unit_address;
        logic       standard_interface;
        logic       tape_attached;
        logic [1:0] parity_mode;
    } cfg_t;

    typedef struct packed {
        logic [5:0] mode_flags;
        logic [2:0] status_bits;
        logic       done;
    } state_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] device_number;
        logic [5:0] command_code;
        logic [5:0] char_in;
        logic       end_of_record;
        logic       write_error;
    } item_t;

    typedef struct packed {
        logic [5:0] response;
        logic       punch_valid;
        logic [7:0] punch_byte;
        logic       done_flag;
    } result_t;

    // zone translation of a 6-bit character to tape code
    function automatic logic [7:0] map_zone(input logic [5:0] c, input logic beta);
        logic [7:0] d;
        d = {4'b0, c[3:0]};
        case (c[5:4])
            2'b00:   d = d | 8'o060;
            2'b01:   d = d | 8'o040;
            2'b10:   d = d | (beta ? 8'o140 : 8'o100);
            default: d = d | (beta ? 8'o160 : 8'o120);
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

@@ rtl/ptpc_step.sv @@
`default_nettype none

// One item against the current unit state: next state and result word.
module ptpc_step
    import ptpc_pkg::*;
(
    input  var cfg_t    cfg,
    input  var state_t  st,
    input  var item_t   item,
    output state_t      st_next,
    output result_t     res
);

    logic [5:0] mf;
    logic [2:0] sb;
    logic       dn;
    logic [5:0] resp;
    logic       pv;
    logic [7:0] data;
    logic       have;
    logic       addressed;
    logic       busy;
    logic [5:0] ch;
    logic [5:0] cmd;

    always_comb
    begin
        mf   = st.mode_flags;
        sb   = st.status_bits;
        dn   = st.done;
        resp = '0;
        pv   = 1'b0;
        data = '0;
        have = 1'b0;
        ch   = item.char_in;
        cmd  = item.command_code;
        busy = st.mode_flags[4];
        addressed = (item.device_number == cfg.unit_address);

        case (kind_t'(item.kind))
            KIND_TICK:
            begin
                if ((mf & M_DISC) != '0)
                begin
                    mf = mf & M_ALPHA;
                    dn = 1'b1;
                end
                else if (!busy)
                begin
                    mf = st.mode_flags;
                end
                else if (!cfg.tape_attached)
                begin
                    mf = mf & M_ALPHA;
                    sb = S_TERM;
                    dn = 1'b1;
                end
                else
                begin
                    if ((mf & M_BLANK) != '0)
                    begin
                        have = 1'b1;
                    end
                    else if ((mf & M_BIN) != '0)
                    begin
                        data = map_zone(ch, 1'b0);
                        have = 1'b1;
                    end
                    else if (ch == CH_ALPHA)
                    begin
                        mf = (mf & M_HOLD) | M_ALPHA;
                    end
                    else if (ch == CH_BETA)
                    begin
                        mf = mf & M_HOLD;
                    end
                    else if (ch == CH_DELTA)
                    begin
                        mf = (mf & (M_HOLD | M_ALPHA)) | M_DELTA;
                    end
                    else if (ch == CH_DELTA_A)
                    begin
                        mf = mf & (M_HOLD | M_ALPHA);
                    end
                    else if ((mf & M_DELTA) != '0)
                    begin
                        mf   = mf & ~M_DELTA;
                        data = {2'b0, ch};
                        if (ch[5])
                        begin
                            data = data | (X_BAR ^ {2'b0, ch[4], 5'b0});
                        end
                        have = (data != '0);
                    end
                    else
                    begin
                        data = map_zone(ch, (mf & M_ALPHA) == '0);
                        have = 1'b1;
                    end

                    if (have)
                    begin
                        case (cfg.parity_mode)
                            PAR_7P: data = {^data[6:0], data[6:0]};
                            PAR_7X:
                            begin
                                if (data == X_DOLLAR)
                                begin
                                    data = X_POUND;
                                end
                                else if (data == X_BAR)
                                begin
                                    data = X_DOLLAR;
                                end
                            end
                            default: data = data;
                        endcase
                        pv = 1'b1;
                    end

                    if (have && item.write_error)
                    begin
                        mf = mf & (M_DELTA | M_ALPHA);
                        sb = sb | S_TERM | S_ERR;
                        dn = 1'b1;
                    end
                    else if (item.end_of_record)
                    begin
                        mf = mf & (M_DELTA | M_ALPHA);
                        sb = sb | S_TERM;
                        dn = 1'b1;
                    end
                end
            end
            KIND_STD_CMD:
            begin
                if (addressed && cfg.standard_interface && cfg.tape_attached)
                begin
                    case (cmd[5:3])
                        GRP_START:
                        begin
                            if (busy)
                            begin
                                resp = RESP_BUSY;
                            end
                            else
                            begin
                                mf = ((cmd[0] ? 6'b0 : mf) & (M_DELTA | M_ALPHA))
                                     | M_BUSY | {3'b0, cmd[2:0]};
                                sb = '0;
                                dn = 1'b0;
                                resp = RESP_ACK;
                            end
                        end
                        GRP_STAT:
                        begin
                            if (cmd == CMD_SENSE)
                            begin
                                resp = {~sb[2], 4'b0, sb[0]};
                            end
                            else if (cmd == CMD_CLEAR)
                            begin
                                resp = {4'b0, sb[2], 1'b1};
                                sb = '0;
                                dn = 1'b0;
                            end
                        end
                        GRP_CTRL:
                        begin
                            if (cmd == CMD_DISC)
                            begin
                                mf = mf | M_DISC;
                                resp = RESP_ACK;
                            end
                        end
                        default: resp = '0;
                    endcase
                end
            end
            KIND_NSI_CMD:
            begin
                if (addressed && !cfg.standard_interface)
                begin
                    if (cmd[1])
                    begin
                        if (busy)
                        begin
                            mf = mf | M_DISC;
                        end
                    end
                    else if (cmd[0])
                    begin
                        if (busy || !cfg.tape_attached)
                        begin
                            sb = sb | S_OPAT;
                            dn = 1'b1;
                        end
                        else
                        begin
                            mf = cmd[3] ? (mf & M_ALPHA) : M_ALPHA;
                            if (cmd[4])
                            begin
                                mf = mf | M_BIN;
                            end
                            if (cmd[5])
                            begin
                                mf = mf | M_BLANK;
                            end
                            mf = mf | M_BUSY;
                            sb = '0;
                            dn = 1'b0;
                        end
                    end
                end
            end
            default:
            begin
                // status read, non-standard interface only
                if (addressed && !cfg.standard_interface)
                begin
                    resp = {busy, 2'b0, sb};
                    sb = '0;
                    dn = 1'b0;
                end
            end
        endcase

        st_next.mode_flags  = mf;
        st_next.status_bits = sb;
        st_next.done        = dn;
        res.response        = resp;
        res.punch_valid     = pv;
        res.punch_byte      = data;
        res.done_flag       = dn;
    end

endmodule

`default_nettype wire

@@ rtl/paper_tape_punch_controller_core.sv @@
// Paper tape punch controller, one unit.
// Item channel (item_valid/item_ready): kind, device_number, command_code,
// char_in, end_of_record, write_error. Each item yields exactly one result
// on the result channel (result_valid/result_ready): response, punch_valid,
// punch_byte, done_flag.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready;
// index 0 unit address, 1 standard interface, 2 tape attached, 3 punch code.
// Write it only while no item is in flight.
// Structure: two register stages, input register and result register; an item
// is decoded against the unit state as it leaves the input register, and its
// result is offered from then on. Throughput: one item per cycle while results
// are taken; the decode/translate step sits between the two registers.
// Stall: if the result is not taken, the input register still holds one more
// item, then item_ready drops until result_ready returns.
// Reset (rst_n low, async): no items held, config back to unit 8, standard
// interface, no tape, plain 7-bit code; mode flags alpha, status and done clear.
`default_nettype none
`include "assert_macros.svh"

module paper_tape_punch_controller_core
    import ptpc_pkg::*;
(
    input  var logic       clk,
    input  var logic       rst_n,
    // item channel
    input  var logic       item_valid,
    output logic           item_ready,
    input  var logic [1:0] kind,
    input  var logic [5:0] device_number,
    input  var logic [5:0] command_code,
    input  var logic [5:0] char_in,
    input  var logic       end_of_record,
    input  var logic       write_error,
    // result channel
    output logic           result_valid,
    input  var logic       result_ready,
    output logic [5:0]     response,
    output logic           punch_valid,
    output logic [7:0]     punch_byte,
    output logic           done_flag,
    // config channel
    input  var logic       cfg_valid,
    output logic           cfg_ready,
    input  var logic [1:0] cfg_index,
    input  var logic [5:0] cfg_data
);

    cfg_t    cfg_reg;
    state_t  st_reg;
    state_t  st_next;
    item_t   item_reg;
    logic    item_vld_reg;
    result_t res_reg;
    result_t res_next;
    logic    res_vld_reg;

    logic    item_accept;
    logic    advance;

    // decode fires when an item is held and the result slot is free or draining
    assign advance     = item_vld_reg && (!res_vld_reg || result_ready);
    assign item_ready  = !item_vld_reg || advance;
    assign item_accept = item_valid && item_ready;
    assign cfg_ready   = 1'b1;

    ptpc_step u_step (
        .cfg     (cfg_reg),
        .st      (st_reg),
        .item    (item_reg),
        .st_next (st_next),
        .res     (res_next)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.unit_address       <= 6'd8;
            cfg_reg.standard_interface <= 1'b1;
            cfg_reg.tape_attached      <= 1'b0;
            cfg_reg.parity_mode        <= 2'd0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_UNIT_ADDR: cfg_reg.unit_address       <= cfg_data;
                CFG_STD_IF:    cfg_reg.standard_interface <= cfg_data[0];
                CFG_TAPE:      cfg_reg.tape_attached      <= cfg_data[0];
                CFG_PARITY:    cfg_reg.parity_mode        <= cfg_data[1:0];
                default:       cfg_reg.unit_address       <= cfg_reg.unit_address;
            endcase
        end
    end

    // unit state and valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.mode_flags  <= M_ALPHA;
            st_reg.status_bits <= '0;
            st_reg.done        <= 1'b0;
            item_vld_reg       <= 1'b0;
            res_vld_reg        <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                st_reg <= st_next;
            end
            if (item_accept)
            begin
                item_vld_reg <= 1'b1;
            end
            else if (advance)
            begin
                item_vld_reg <= 1'b0;
            end
            if (advance)
            begin
                res_vld_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                res_vld_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            item_reg.kind          <= kind;
            item_reg.device_number <= device_number;
            item_reg.command_code  <= command_code;
            item_reg.char_in       <= char_in;
            item_reg.end_of_record <= end_of_record;
            item_reg.write_error   <= write_error;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign result_valid = res_vld_reg;
    assign response     = res_reg.response;
    assign punch_valid  = res_reg.punch_valid;
    assign punch_byte   = res_reg.punch_byte;
    assign done_flag    = res_reg.done_flag;

    // a punched byte never comes with a command reply
    `ASSERT_NEVER(a_punch_no_resp, result_valid && punch_valid && (response != '0), "punch with reply")
    // no punch means a zero byte
    `ASSERT_NEVER(a_idle_byte_zero, result_valid && !punch_valid && (punch_byte != '0), "stray byte")
    // unit state only moves when an item is decoded
    `ASSERT_PROP(a_state_hold, !advance |=> $stable(st_reg), "state changed without item")
    // full input stage behind a stalled result blocks new items
    `ASSERT_NEVER(a_stall_blocks, item_vld_reg && res_vld_reg && !result_ready && item_ready, "overrun")

endmodule

`default_nettype wire
